>>> sv/ams_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ams_pkg
// Shared types and codes of the accumulator machine.
// ----------------------------------------------------------------------------
package ams_pkg;

  localparam int ADDR_BITS_DEF = 8;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_EXEC  = 2'd1,
    MODE_SETPC = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BLANK  = 2'd0,
    KIND_INSTR  = 2'd1,
    KIND_NUMBER = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_LOAD  = 4'd4,
    OP_STORE = 4'd5,
    OP_JUMP  = 4'd6,
    OP_JZ    = 4'd7,
    OP_PRINT = 4'd8,
    OP_HALT  = 4'd9
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HALT    = 2'd1,
    ST_ILLEGAL = 2'd2,
    ST_SAT     = 2'd3
  } status_t;

  localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] INT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  opcode;
    logic [31:0] value;
  } mem_word_t;

  // result of a serial arithmetic unit
  typedef struct packed {
    logic        done;
    logic        sat;
    logic [31:0] value;
  } res_t;

endpackage

>>> sv/ams_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ams_in_if / ams_out_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface ams_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  address;
  logic [1:0]  word_kind;
  logic [3:0]  word_opcode;
  logic signed [31:0] word_value;

  modport source (output valid, mode, address, word_kind, word_opcode, word_value,
                  input ready);
  modport sink (input valid, mode, address, word_kind, word_opcode, word_value,
                output ready);
endinterface

interface ams_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  program_counter;
  logic signed [31:0] accumulator_value;
  logic        printed;

  modport source (output valid, status, program_counter, accumulator_value, printed,
                  input ready);
  modport sink (input valid, status, program_counter, accumulator_value, printed,
                output ready);
endinterface

>>> sv/ams_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ams_mem
// Tagged word memory, one write and one registered read, blanked after reset.
// ----------------------------------------------------------------------------
module ams_mem #(
  parameter int ADDR_BITS = ams_pkg::ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  ams_pkg::mem_word_t   wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output ams_pkg::mem_word_t   rdata,
  output logic                 busy
);

  ams_pkg::mem_word_t mem [2**ADDR_BITS];
  ams_pkg::mem_word_t rdata_r;
  logic [ADDR_BITS:0] clr_r;

  assign busy  = ~clr_r[ADDR_BITS];
  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (busy) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_r[ADDR_BITS-1:0]] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

>>> sv/ams_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ams_mul
// Bit-serial fixed-point multiply, floor shift and saturation.
// ----------------------------------------------------------------------------
module ams_mul #(
  parameter int FRAC_BITS = ams_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   a,
  input  logic [31:0]   b,
  output ams_pkg::res_t res
);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_NEG, M_SAT} mstate_t;

  mstate_t       st_r;
  logic [4:0]    cnt_r;
  logic [31:0]   ma_r, mb_r;
  logic [63:0]   p_r;
  logic          neg_r;
  ams_pkg::res_t res_r;

  logic [32:0]        sum;
  logic signed [63:0] sh;
  logic               fits;

  assign sum  = {1'b0, p_r[63:32]} + (mb_r[0] ? {1'b0, ma_r} : 33'd0);
  assign sh   = $signed(p_r) >>> FRAC_BITS;
  assign fits = (&sh[63:31]) | ~(|sh[63:31]);
  assign res  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= M_IDLE;
      res_r.done <= 1'b0;
    end else begin
      res_r.done <= 1'b0;
      unique case (st_r)
        M_IDLE: begin
          if (start) begin
            ma_r  <= a[31] ? -a : a;
            mb_r  <= b[31] ? -b : b;
            neg_r <= a[31] ^ b[31];
            p_r   <= '0;
            cnt_r <= '0;
            st_r  <= M_RUN;
          end
        end
        M_RUN: begin
          p_r   <= {sum, p_r[31:1]};
          mb_r  <= {1'b0, mb_r[31:1]};
          cnt_r <= cnt_r + 1'b1;
          if (&cnt_r) st_r <= M_NEG;
        end
        M_NEG: begin
          if (neg_r) p_r <= -p_r;
          st_r <= M_SAT;
        end
        M_SAT: begin
          res_r.done  <= 1'b1;
          res_r.sat   <= ~fits;
          res_r.value <= fits ? sh[31:0] : (sh[63] ? ams_pkg::INT_MIN : ams_pkg::INT_MAX);
          st_r        <= M_IDLE;
        end
        default: st_r <= M_IDLE;
      endcase
    end
  end

endmodule

>>> sv/ams_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ams_div
// Restoring fixed-point divide, one quotient bit a cycle, with saturation.
// ----------------------------------------------------------------------------
module ams_div #(
  parameter int FRAC_BITS = ams_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   a,
  input  logic [31:0]   b,
  output ams_pkg::res_t res
);

  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW);
  localparam logic [CW-1:0] LAST = CW'(DW - 1);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_t;

  dstate_t       st_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] quo_r;
  logic [31:0]   rem_r, d_r;
  logic          neg_r;
  ams_pkg::res_t res_r;

  logic [32:0] rem_sh, rem_sub;
  logic        ge;
  logic [DW:0] qx;
  logic        sat;
  logic [31:0] ma;

  assign ma      = a[31] ? -a : a;
  assign rem_sh  = {rem_r, quo_r[DW-1]};
  assign rem_sub = rem_sh - {1'b0, d_r};
  assign ge      = rem_sh >= {1'b0, d_r};
  assign qx      = {1'b0, quo_r};
  // negative side reaches one further than positive
  assign sat     = neg_r ? ((|qx[DW:32]) | (qx[31] & (|qx[30:0]))) : (|qx[DW:31]);
  assign res     = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= D_IDLE;
      res_r.done <= 1'b0;
    end else begin
      res_r.done <= 1'b0;
      unique case (st_r)
        D_IDLE: begin
          if (start) begin
            quo_r <= DW'(ma) << FRAC_BITS;
            d_r   <= b[31] ? -b : b;
            neg_r <= a[31] ^ b[31];
            rem_r <= '0;
            cnt_r <= '0;
            st_r  <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= ge ? rem_sub[31:0] : rem_sh[31:0];
          quo_r <= {quo_r[DW-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST) st_r <= D_FIX;
        end
        D_FIX: begin
          res_r.done <= 1'b1;
          res_r.sat  <= sat;
          if (sat) begin
            res_r.value <= neg_r ? ams_pkg::INT_MIN : ams_pkg::INT_MAX;
          end else begin
            res_r.value <= neg_r ? -qx[31:0] : qx[31:0];
          end
          st_r <= D_IDLE;
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

endmodule

>>> sv/accumulator_machine_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_machine_step
// One-accumulator machine stepping one command word at a time.
// ----------------------------------------------------------------------------
// in_ch carries command words: write a memory word, set the program counter or
// execute the instruction at the program counter. out_ch returns one result
// word per command: status, program counter, accumulator and a print flag.
// Commands are taken one at a time. Write and set-pc pass through the done
// state to the result register; an execute through fetch, operate (for an
// instruction) and done, MULTIPLY waiting on the multiplier (one multiplier
// bit a cycle over 32 bits), DIVIDE on the divider (one quotient bit a cycle).
// After reset the memory is blanked, one word a cycle over all 2^ADDR_BITS
// words; in_ch.ready stays low during that pass. pc and accumulator reset to 0.
// A finished result waits in the output register while out_ch.ready is low;
// the next command is already taken meanwhile, and its result waits until the
// output register is free.
// ----------------------------------------------------------------------------
module accumulator_machine_step #(
  parameter int ADDR_BITS = ams_pkg::ADDR_BITS_DEF,
  parameter int FRAC_BITS = ams_pkg::FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  ams_in_if.sink    in_ch,
  ams_out_if.source out_ch
);

  typedef enum logic [2:0] {S_IDLE, S_FETCH, S_OPER, S_MUL, S_DIV, S_DONE} state_t;

  state_t                 state_r;
  logic [ADDR_BITS-1:0]   pc_r;
  logic [31:0]            acc_r;
  logic [3:0]             op_r;
  logic [ADDR_BITS-1:0]   oa_r;
  logic [1:0]             status_r;
  logic                   printed_r;

  logic                   out_valid_r;
  logic [1:0]             out_status_r;
  logic [7:0]             out_pc_r;
  logic [31:0]            out_acc_r;
  logic                   out_printed_r;

  logic                   mem_busy;
  logic                   mem_we;
  logic [ADDR_BITS-1:0]   mem_waddr, mem_raddr;
  ams_pkg::mem_word_t     mem_wdata, mem_rdata;
  logic                   accept;
  logic                   mul_start, div_start;
  ams_pkg::res_t          mul_res, div_res;

  logic [ADDR_BITS-1:0]   pc_next;
  logic [ADDR_BITS-1:0]   in_addr;
  logic [31:0]            opnd;
  logic [32:0]            sum;
  logic                   sum_ovf;
  logic [31:0]            sum_val;
  logic [15:0]            pc_wide;

  assign in_ch.ready = (state_r == S_IDLE) && !mem_busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pc_next     = pc_r + 1'b1;
  assign in_addr     = ADDR_BITS'(in_ch.address);
  assign opnd        = (mem_rdata.kind == ams_pkg::KIND_NUMBER) ? mem_rdata.value : 32'd0;
  assign pc_wide     = 16'(pc_r);

  // add or subtract with one extra bit for the overflow check
  always_comb begin
    if (op_r == ams_pkg::OP_SUB) begin
      sum = {acc_r[31], acc_r} - {opnd[31], opnd};
    end else begin
      sum = {acc_r[31], acc_r} + {opnd[31], opnd};
    end
    sum_ovf = sum[32] ^ sum[31];
    sum_val = sum_ovf ? (sum[32] ? ams_pkg::INT_MIN : ams_pkg::INT_MAX) : sum[31:0];
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = in_addr;
    mem_wdata.kind   = (in_ch.word_kind == ams_pkg::KIND_SPARE) ? ams_pkg::KIND_BLANK
                                                                 : in_ch.word_kind;
    mem_wdata.opcode = in_ch.word_opcode;
    mem_wdata.value  = in_ch.word_value;
    if (state_r == S_OPER && op_r == ams_pkg::OP_STORE) begin
      mem_we           = 1'b1;
      mem_waddr        = oa_r;
      mem_wdata.kind   = ams_pkg::KIND_NUMBER;
      mem_wdata.opcode = '0;
      mem_wdata.value  = acc_r;
    end else if (accept && in_ch.mode == ams_pkg::MODE_WRITE) begin
      mem_we = 1'b1;
    end
  end

  assign mem_raddr = (state_r == S_FETCH) ? mem_rdata.value[ADDR_BITS-1:0] : pc_r;
  assign mul_start = (state_r == S_OPER) && (op_r == ams_pkg::OP_MUL);
  assign div_start = (state_r == S_OPER) && (op_r == ams_pkg::OP_DIV) && (opnd != 32'd0);

  ams_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  ams_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (acc_r),
    .b     (opnd),
    .res   (mul_res)
  );

  ams_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (acc_r),
    .b     (opnd),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          status_r  <= ams_pkg::ST_OK;
          printed_r <= 1'b0;
          if (accept) begin
            if (in_ch.mode == ams_pkg::MODE_EXEC) begin
              state_r <= S_FETCH;
            end else begin
              if (in_ch.mode == ams_pkg::MODE_SETPC) pc_r <= in_addr;
              state_r <= S_DONE;
            end
          end
        end
        S_FETCH: begin
          op_r    <= mem_rdata.opcode;
          oa_r    <= mem_rdata.value[ADDR_BITS-1:0];
          state_r <= S_DONE;
          if (mem_rdata.kind == ams_pkg::KIND_BLANK || mem_rdata.kind == ams_pkg::KIND_SPARE) begin
            pc_r <= pc_next;
          end else if (mem_rdata.kind == ams_pkg::KIND_NUMBER || mem_rdata.opcode > 4'd9) begin
            status_r <= ams_pkg::ST_ILLEGAL;
          end else begin
            state_r <= S_OPER;
          end
        end
        S_OPER: begin
          state_r <= S_DONE;
          pc_r    <= pc_next;
          case (op_r)
            ams_pkg::OP_ADD, ams_pkg::OP_SUB: begin
              acc_r <= sum_val;
              if (sum_ovf) status_r <= ams_pkg::ST_SAT;
            end
            ams_pkg::OP_MUL: begin
              pc_r    <= pc_r;
              state_r <= S_MUL;
            end
            ams_pkg::OP_DIV: begin
              if (opnd == 32'd0) begin
                status_r <= ams_pkg::ST_SAT;
                if (acc_r[31]) acc_r <= ams_pkg::INT_MIN;
                else if (acc_r != 32'd0) acc_r <= ams_pkg::INT_MAX;
              end else begin
                pc_r    <= pc_r;
                state_r <= S_DIV;
              end
            end
            ams_pkg::OP_LOAD:  acc_r <= opnd;
            ams_pkg::OP_JUMP:  pc_r <= oa_r;
            ams_pkg::OP_JZ:    if (acc_r == 32'd0) pc_r <= oa_r;
            ams_pkg::OP_PRINT: printed_r <= 1'b1;
            ams_pkg::OP_HALT: begin
              pc_r     <= pc_r;
              status_r <= ams_pkg::ST_HALT;
            end
            default: ;
          endcase
        end
        S_MUL: begin
          if (mul_res.done) begin
            acc_r   <= mul_res.value;
            pc_r    <= pc_next;
            if (mul_res.sat) status_r <= ams_pkg::ST_SAT;
            state_r <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            acc_r   <= div_res.value;
            pc_r    <= pc_next;
            if (div_res.sat) status_r <= ams_pkg::ST_SAT;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= status_r;
            out_pc_r      <= pc_wide[7:0];
            out_acc_r     <= acc_r;
            out_printed_r <= printed_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.program_counter   = out_pc_r;
  assign out_ch.accumulator_value = out_acc_r;
  assign out_ch.printed           = out_printed_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    mem_busy |-> !in_ch.ready)
    else $error("command taken during memory clear");

  a_mul_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    mul_res.done |-> state_r == S_MUL)
    else $error("multiplier result outside multiply wait");

  a_div_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == S_DIV)
    else $error("divider result outside divide wait");

  a_print_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.printed) |-> out_ch.status == ams_pkg::ST_OK)
    else $error("print flagged with bad status");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("command taken without leaving idle");

endmodule
